[rtl/core/emg_envelope_intent_classifier_macros.svh]
// ----------------------------------------------------------------------------
// EMG envelope intent classifier: assertion macros
// Shared assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EMG_ENVELOPE_INTENT_CLASSIFIER_MACROS_SVH
`define EMG_ENVELOPE_INTENT_CLASSIFIER_MACROS_SVH

`ifndef SYNTH
// Check on every rising edge, masked while reset is active.
`define EEIC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("eeic: assertion failed");
// Check on every rising edge, reset included.
`define EEIC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("eeic: assertion failed");
`else
`define EEIC_ASSERT(lbl, clk, rstn, prop)
`define EEIC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/core/eeic_pkg.sv]
// ----------------------------------------------------------------------------
// eeic_pkg
// Types and fixed constants shared by the EMG envelope intent classifier.
// ----------------------------------------------------------------------------
package eeic_pkg;

	localparam int CODE_W    = 12;
	localparam int LEVEL_W   = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_CODE     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLEX_ON_LEVEL   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLEX_OFF_LEVEL  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_ON_LEVEL    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_OFF_LEVEL   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLEX_FULL_LEVEL = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_CEILING   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW   = 4'd7;

	typedef enum logic [1:0] {
		MOVE_REST,
		MOVE_CLOSE,
		MOVE_OPEN,
		MOVE_COCON
	} eeic_intent_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FL_GO,
		ST_FL_WAIT,
		ST_EL_GO,
		ST_EL_WAIT,
		ST_CLS,
		ST_MUL,
		ST_FRC_GO,
		ST_FRC_WAIT,
		ST_DONE
	} eeic_state_t;

	typedef struct packed {
		logic [CODE_W-1:0]  center_code;
		logic [LEVEL_W-1:0] flex_on_level;
		logic [LEVEL_W-1:0] flex_off_level;
		logic [LEVEL_W-1:0] ext_on_level;
		logic [LEVEL_W-1:0] ext_off_level;
		logic [LEVEL_W-1:0] flex_full_level;
		logic [LEVEL_W-1:0] force_ceiling;
		logic [LEVEL_W-1:0] double_window_frames;
	} eeic_cfg_t;

	typedef struct packed {
		eeic_intent_t intent;
		logic         fired;
	} eeic_decision_t;

endpackage

[rtl/core/eeic_if.sv]
// ----------------------------------------------------------------------------
// eeic channel interfaces
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface eeic_in_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [eeic_pkg::CODE_W-1:0] code_flex;
	logic [eeic_pkg::CODE_W-1:0] code_ext;

	modport source (output valid, command, code_flex, code_ext, input ready);
	modport sink   (input valid, command, code_flex, code_ext, output ready);
endinterface

interface eeic_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  intent;
	logic [eeic_pkg::LEVEL_W-1:0] force_value;
	logic                        double_fired;
	logic [eeic_pkg::LEVEL_W-1:0] flex_level;
	logic [eeic_pkg::LEVEL_W-1:0] ext_level;

	modport source (output valid, intent, force_value, double_fired, flex_level,
		ext_level, input ready);
	modport sink   (input valid, intent, force_value, double_fired, flex_level,
		ext_level, output ready);
endinterface

interface eeic_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [eeic_pkg::CFG_IDX_W-1:0] index;
	logic [eeic_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/eeic_cfg_regs.sv]
// ----------------------------------------------------------------------------
// eeic_cfg_regs
// Configuration register file; takes one write word per cycle.
// ----------------------------------------------------------------------------
module eeic_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	eeic_cfg_if.sink           cfg,
	output eeic_pkg::eeic_cfg_t regs
);
	import eeic_pkg::*;

	eeic_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.center_code          <= 12'd1861;
			regs_q.flex_on_level        <= 16'd3200;
			regs_q.flex_off_level       <= 16'd2000;
			regs_q.ext_on_level         <= 16'd3200;
			regs_q.ext_off_level        <= 16'd2000;
			regs_q.flex_full_level      <= 16'd16000;
			regs_q.force_ceiling        <= 16'd65535;
			regs_q.double_window_frames <= 16'd50;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER_CODE:     regs_q.center_code          <= cfg.data[CODE_W-1:0];
				REG_FLEX_ON_LEVEL:   regs_q.flex_on_level        <= cfg.data;
				REG_FLEX_OFF_LEVEL:  regs_q.flex_off_level       <= cfg.data;
				REG_EXT_ON_LEVEL:    regs_q.ext_on_level         <= cfg.data;
				REG_EXT_OFF_LEVEL:   regs_q.ext_off_level        <= cfg.data;
				REG_FLEX_FULL_LEVEL: regs_q.flex_full_level      <= cfg.data;
				REG_FORCE_CEILING:   regs_q.force_ceiling        <= cfg.data;
				REG_DOUBLE_WINDOW:   regs_q.double_window_frames <= cfg.data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

endmodule

[rtl/core/eeic_divider.sv]
// ----------------------------------------------------------------------------
// eeic_divider
// Shared restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "emg_envelope_intent_classifier_macros.svh"

module eeic_divider #(
	parameter int DVD_W = 32,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DVS_W:0]    trial;
	logic              fits;
	logic [DVS_W:0]    trial_sub;

	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign fits      = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract when the divisor fits
			rem_q <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	`EEIC_ASSERT(a_no_start_busy, clk, arst_n, start |-> !busy_q)
	`EEIC_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))
	`EEIC_ASSERT(a_busy_from_start, clk, arst_n, $rose(busy_q) |-> $past(start))

endmodule

[rtl/core/eeic_intent.sv]
// ----------------------------------------------------------------------------
// eeic_intent
// Hysteresis classifier, debounce and double co-contraction detector.
// ----------------------------------------------------------------------------
module eeic_intent (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           update,
	input  logic [eeic_pkg::LEVEL_W-1:0]   flex_level,
	input  logic [eeic_pkg::LEVEL_W-1:0]   ext_level,
	input  eeic_pkg::eeic_cfg_t            regs,
	output eeic_pkg::eeic_decision_t       decision
);
	import eeic_pkg::*;

	localparam logic [2:0] AGREE_MAX = 3'd5;
	localparam logic [2:0] RUN_REST  = 3'd5;
	localparam logic [2:0] RUN_MOVE  = 3'd3;

	eeic_intent_t       cur_q, cand_q, raw, cur_nx;
	logic [2:0]         agree_q, agree_nx;
	logic               was_q, armed_q, armed_nx;
	logic [LEVEL_W-1:0] fso_q, fso_inc, fso_nx;
	logic               fh, eh, fq, eq, now_cocon, onset, fire;
	eeic_decision_t     dec_q;

	assign decision = dec_q;

	always_comb begin
		fh = flex_level > regs.flex_on_level;
		eh = ext_level > regs.ext_on_level;
		fq = flex_level < regs.flex_off_level;
		eq = ext_level < regs.ext_off_level;
		if (fh && eh)
			raw = MOVE_COCON;
		else if (fh)
			raw = MOVE_CLOSE;
		else if (eh)
			raw = MOVE_OPEN;
		else if (fq && eq)
			raw = MOVE_REST;
		else
			raw = cur_q;

		// agreement run saturates at the longest debounce length
		if (raw == cand_q)
			agree_nx = (agree_q == AGREE_MAX) ? agree_q : agree_q + 3'd1;
		else
			agree_nx = 3'd1;
		cur_nx = (agree_nx >= ((raw == MOVE_REST) ? RUN_REST : RUN_MOVE)) ? raw : cur_q;

		fso_inc   = (fso_q == '1) ? fso_q : fso_q + 1'b1;
		now_cocon = cur_nx == MOVE_COCON;
		onset     = now_cocon && !was_q;
		fire      = onset && armed_q && (fso_inc < regs.double_window_frames);
		armed_nx  = onset ? !fire : armed_q;
		fso_nx    = (onset && !fire) ? '0 : fso_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= MOVE_REST;
			cand_q  <= MOVE_REST;
			agree_q <= '0;
			was_q   <= 1'b0;
			armed_q <= 1'b0;
			fso_q   <= '0;
			dec_q   <= '{intent: MOVE_REST, fired: 1'b0};
		end else if (update) begin
			cur_q   <= cur_nx;
			cand_q  <= raw;
			agree_q <= agree_nx;
			was_q   <= now_cocon;
			armed_q <= armed_nx;
			fso_q   <= fso_nx;
			dec_q   <= '{intent: cur_nx, fired: fire};
		end
	end

endmodule

[rtl/core/emg_envelope_intent_classifier.sv]
// ----------------------------------------------------------------------------
// emg_envelope_intent_classifier
// Mean absolute value envelope per EMG channel, hysteresis intent classifier
// with debounce, linear force map and double co-contraction detection.
// ----------------------------------------------------------------------------
//
// Channel     Dir  Word                                              Accepted when
// sample_in   in   command, code_flex, code_ext                      valid && ready
// result_out  out  intent, force_value, double_fired, flex/ext level valid && ready
// cfg         in   index, data (register write)                      valid && ready
//
// Sample words may follow back to back while idle.
// A frame word runs three divisions on one shared restoring divider with a
// DVD_W-bit dividend (DVD_W = max(sum width + FRAC_BITS, 32), 32 at
// defaults), fewer when the frame is empty or the force clamps. Reset clears
// sums, count, intent state and result valid; registers take their reset
// values. A held result stalls only the end of the next frame.
//
`include "emg_envelope_intent_classifier_macros.svh"

module emg_envelope_intent_classifier #(
	parameter int MAX_SAMPLES = 1024,
	parameter int FRAC_BITS   = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	eeic_in_if.sink   sample_in,
	eeic_out_if.source result_out,
	eeic_cfg_if.sink  cfg
);
	import eeic_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = CODE_W + CNT_W;
	localparam int LVL_W = SUM_W + FRAC_BITS;
	localparam int DVD_W = (LVL_W > 32) ? LVL_W : 32;
	localparam int DVS_W = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;

	eeic_cfg_t      regs;
	eeic_decision_t decision;
	eeic_state_t    state_q, state_nx;

	// accumulators and frame results
	logic [SUM_W-1:0]   fsum_q, esum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LEVEL_W-1:0] fl_q, el_q, frc_q;
	logic [31:0]        prod_q;

	// result register
	logic               out_valid_q;
	eeic_intent_t       out_intent_q;
	logic [LEVEL_W-1:0] out_force_q, out_fl_q, out_el_q;
	logic               out_fired_q;

	// shared divider
	logic             div_start, div_busy, div_done;
	logic [DVD_W-1:0] div_dvd, div_quo;
	logic [DVS_W-1:0] div_dvs;
	logic [LEVEL_W-1:0] div_level;

	logic               in_fire, is_frame, is_sample, out_free;
	logic [CODE_W-1:0]  dev_flex, dev_ext;
	logic               frc_zero, frc_full, cls_upd;

	eeic_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	eeic_divider #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	eeic_intent u_intent (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (cls_upd),
		.flex_level (fl_q),
		.ext_level  (el_q),
		.regs       (regs),
		.decision   (decision)
	);

	assign in_fire   = sample_in.valid && sample_in.ready;
	assign is_frame  = in_fire && sample_in.command;
	assign is_sample = in_fire && !sample_in.command;
	assign out_free  = !out_valid_q || result_out.ready;

	// rectify around the programmed midpoint
	assign dev_flex = (sample_in.code_flex >= regs.center_code) ?
		sample_in.code_flex - regs.center_code : regs.center_code - sample_in.code_flex;
	assign dev_ext  = (sample_in.code_ext >= regs.center_code) ?
		sample_in.code_ext - regs.center_code : regs.center_code - sample_in.code_ext;

	// saturate a mean quotient to the level width
	assign div_level = (|div_quo[DVD_W-1:LEVEL_W]) ? '1 : div_quo[LEVEL_W-1:0];

	// force clamps, decided on the flex level alone
	assign frc_zero = fl_q <= regs.flex_on_level;
	assign frc_full = (regs.flex_full_level <= regs.flex_on_level) ||
		(fl_q >= regs.flex_full_level);

	// ---- sequencer: next state ----
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (is_frame)
					state_nx = (cnt_q == '0) ? ST_CLS : ST_FL_GO;
			end
			ST_FL_GO:   state_nx = ST_FL_WAIT;
			ST_FL_WAIT: begin
				if (div_done)
					state_nx = ST_EL_GO;
			end
			ST_EL_GO:   state_nx = ST_EL_WAIT;
			ST_EL_WAIT: begin
				if (div_done)
					state_nx = ST_CLS;
			end
			ST_CLS:     state_nx = (frc_zero || frc_full) ? ST_DONE : ST_MUL;
			ST_MUL:     state_nx = ST_FRC_GO;
			ST_FRC_GO:  state_nx = ST_FRC_WAIT;
			ST_FRC_WAIT: begin
				if (div_done)
					state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_nx = ST_IDLE;
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	// ---- sequencer: outputs ----
	always_comb begin
		sample_in.ready = 1'b0;
		div_start       = 1'b0;
		div_dvd         = DVD_W'(prod_q);
		div_dvs         = DVS_W'(regs.flex_full_level - regs.flex_on_level);
		cls_upd         = 1'b0;
		case (state_q)
			ST_IDLE:  sample_in.ready = 1'b1;
			ST_FL_GO: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(fsum_q) << FRAC_BITS;
				div_dvs   = DVS_W'(cnt_q);
			end
			ST_EL_GO: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(esum_q) << FRAC_BITS;
				div_dvs   = DVS_W'(cnt_q);
			end
			ST_CLS:    cls_upd   = 1'b1;
			ST_FRC_GO: div_start = 1'b1;
			default: begin
				// hold defaults
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// accumulate samples; ignore them once the frame is full, clear after use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsum_q <= '0;
			esum_q <= '0;
			cnt_q  <= '0;
		end else if (state_q == ST_CLS) begin
			fsum_q <= '0;
			esum_q <= '0;
			cnt_q  <= '0;
		end else if (is_sample && (cnt_q < CNT_W'(MAX_SAMPLES))) begin
			fsum_q <= fsum_q + SUM_W'(dev_flex);
			esum_q <= esum_q + SUM_W'(dev_ext);
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	// frame datapath
	always_ff @(posedge clk) begin
		if (is_frame) begin
			fl_q <= '0;
			el_q <= '0;
		end
		if (state_q == ST_FL_WAIT && div_done)
			fl_q <= div_level;
		if (state_q == ST_EL_WAIT && div_done)
			el_q <= div_level;
		if (state_q == ST_CLS)
			frc_q <= frc_zero ? '0 : regs.force_ceiling;
		if (state_q == ST_MUL)
			prod_q <= {16'd0, fl_q - regs.flex_on_level} * {16'd0, regs.force_ceiling};
		if (state_q == ST_FRC_WAIT && div_done)
			frc_q <= div_quo[LEVEL_W-1:0];
	end

	// result register: free the input side while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (result_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_intent_q <= decision.intent;
			out_fired_q  <= decision.fired;
			out_force_q  <= frc_q;
			out_fl_q     <= fl_q;
			out_el_q     <= el_q;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.intent       = out_intent_q;
	assign result_out.force_value  = out_force_q;
	assign result_out.double_fired = out_fired_q;
	assign result_out.flex_level   = out_fl_q;
	assign result_out.ext_level    = out_el_q;

	`EEIC_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |=> !out_valid_q)
	`EEIC_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(MAX_SAMPLES))
	`EEIC_ASSERT(a_result_from_done, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
	`EEIC_ASSERT(a_frame_clears, clk, arst_n, (state_q == ST_CLS) |=> (cnt_q == '0))
	`EEIC_ASSERT(a_div_idle, clk, arst_n, (state_q == ST_IDLE) |-> !div_busy)

endmodule
